### design/gf2_rank_xor_basis_defines.svh
// assertion macros for the gf2 rank block
`ifndef GF2_RANK_XOR_BASIS_DEFINES_SVH
`define GF2_RANK_XOR_BASIS_DEFINES_SVH

`ifndef SYNTHESIS
`define GXB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gxb check failed");
`define GXB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gxb check failed");
`else
`define GXB_ASSERT_IMP(lbl, ante, cons)
`define GXB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/gxb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gxb_pkg;

  localparam int unsigned ROW_BITS_DEF = 64;
  localparam int unsigned ROW_W        = 64;
  localparam int unsigned PIVOT_W      = 6;
  localparam int unsigned RANK_W       = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic store;
    logic reduce;
    logic publish;
  } gxb_cmd_t;

  typedef struct packed {
    logic x_zero;
    logic ev_valid;
    logic bit_set;
    logic slot_full;
    logic ev_last;
    logic out_free;
  } gxb_sts_t;

endpackage
`default_nettype wire

### design/gxb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gxb_in_if;
  import gxb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_value;
  logic             last_of_set;

  modport source (output valid, output row_value, output last_of_set, input ready);
  modport sink   (input valid, input row_value, input last_of_set, output ready);
endinterface

interface gxb_out_if;
  import gxb_pkg::*;
  logic               valid;
  logic               ready;
  logic               independent;
  logic [PIVOT_W-1:0] pivot_bit;
  logic [RANK_W-1:0]  running_rank;
  logic               set_done;

  modport source (output valid, output independent, output pivot_bit,
                  output running_rank, output set_done, input ready);
  modport sink   (input valid, input independent, input pivot_bit,
                  input running_rank, input set_done, output ready);
endinterface
`default_nettype wire

### design/gxb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gxb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gxb_pkg::gxb_sts_t sts,
  output gxb_pkg::gxb_cmd_t cmd
);
  import gxb_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       store_hit;
  logic       scan_done;

  // empty slot met on a set bit ends the scan with a store
  assign store_hit = sts.ev_valid & sts.bit_set & ~sts.slot_full & ~sts.x_zero;
  assign scan_done = sts.x_zero | store_hit | (sts.ev_valid & sts.ev_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.store  = store_hit;
        cmd.reduce = sts.ev_valid & sts.bit_set & sts.slot_full;
      end
      ST_FINISH: begin
        cmd.publish = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/gxb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gf2_rank_xor_basis_defines.svh"
module gxb_datapath #(
  parameter int unsigned ROW_BITS = gxb_pkg::ROW_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gxb_pkg::gxb_cmd_t           cmd,
  output gxb_pkg::gxb_sts_t           sts,
  input  logic [gxb_pkg::ROW_W-1:0]   in_row_value,
  input  logic                        in_last_of_set,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_independent,
  output logic [gxb_pkg::PIVOT_W-1:0] out_pivot_bit,
  output logic [gxb_pkg::RANK_W-1:0]  out_running_rank,
  output logic                        out_set_done
);
  import gxb_pkg::*;

  localparam int unsigned IDX_W   = $clog2(ROW_BITS);
  localparam int unsigned RANK_IW = $clog2(ROW_BITS + 1);

  logic [ROW_BITS-1:0] mem_r [ROW_BITS];
  logic [ROW_BITS-1:0] rdata_r;
  logic [ROW_BITS-1:0] x_r;
  logic [ROW_BITS-1:0] valid_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    rd_idx_nxt;
  logic [IDX_W-1:0]    ev_idx_r;
  logic [IDX_W-1:0]    pivot_r;
  logic                ev_valid_r;
  logic                last_r;
  logic                indep_r;
  logic [RANK_IW-1:0]  rank_r;
  logic                out_valid_r;
  logic                out_indep_r;
  logic [PIVOT_W-1:0]  out_pivot_r;
  logic [RANK_W-1:0]   out_rank_r;
  logic                out_done_r;

  assign rd_idx_nxt = (rd_idx_r == '0) ? '0 : rd_idx_r - IDX_W'(1);

  // basis store, one registered read per cycle while scanning
  always_ff @(posedge clk) begin
    if (cmd.scan) rdata_r <= mem_r[rd_idx_r];
    if (cmd.store) mem_r[ev_idx_r] <= x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      valid_r     <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ev_valid_r <= 1'b0;
      end else if (cmd.scan) begin
        ev_valid_r <= 1'b1;
      end
      // set ends: basis and rank start over
      if (cmd.publish && last_r) begin
        valid_r <= '0;
        rank_r  <= '0;
      end else if (cmd.store) begin
        valid_r[ev_idx_r] <= 1'b1;
        rank_r            <= rank_r + RANK_IW'(1);
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= in_row_value[ROW_BITS-1:0];
      rd_idx_r <= IDX_W'(ROW_BITS - 1);
      last_r   <= in_last_of_set;
      indep_r  <= 1'b0;
      pivot_r  <= '0;
    end else begin
      if (cmd.scan) begin
        rd_idx_r <= rd_idx_nxt;
        ev_idx_r <= rd_idx_r;
      end
      if (cmd.reduce) x_r <= x_r ^ rdata_r;
      if (cmd.store) begin
        indep_r <= 1'b1;
        pivot_r <= ev_idx_r;
      end
    end
    if (cmd.publish) begin
      out_indep_r <= indep_r;
      out_pivot_r <= PIVOT_W'(pivot_r);
      out_rank_r  <= RANK_W'(rank_r);
      out_done_r  <= last_r;
    end
  end

  assign sts.x_zero    = (x_r == '0);
  assign sts.ev_valid  = ev_valid_r;
  assign sts.bit_set   = x_r[ev_idx_r];
  assign sts.slot_full = valid_r[ev_idx_r];
  assign sts.ev_last   = (ev_idx_r == '0);
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid        = out_valid_r;
  assign out_independent  = out_indep_r;
  assign out_pivot_bit    = out_pivot_r;
  assign out_running_rank = out_rank_r;
  assign out_set_done     = out_done_r;

  `GXB_ASSERT_IMP(a_store_empty, cmd.store, !valid_r[ev_idx_r] && x_r[ev_idx_r])
  `GXB_ASSERT_IMP(a_rank_count, 1'b1, $countones(valid_r) == int'(rank_r))
  `GXB_ASSERT_NXT(a_set_clear, cmd.publish && last_r, rank_r == '0 && valid_r == '0)
  `GXB_ASSERT_IMP(a_no_overwrite, cmd.publish, !out_valid_r || out_ready)

endmodule
`default_nettype wire

### design/gf2_rank_xor_basis.sv
`timescale 1ns / 1ps
`default_nettype none
// incremental gf(2) rank of a stream of row vectors
// in_ch: one row per item (row_value, last_of_set); bits above ROW_BITS are ignored
// out_ch: one result per row (independent, pivot_bit, running_rank, set_done)
// the row is reduced against a basis store indexed by leading bit, highest bit first;
// the store is read once per cycle, one slot after another from the top bit down,
// ending early when the row reduces to zero or meets an empty slot
// one row is in work at a time; in_ch.ready is high while the block waits for a row
// a finished result sits in an output register; the next row is accepted while it waits,
// and only the hand-over of the following result stalls on a busy receiver
// after the result of a row marked last_of_set, the basis and rank are cleared
// at once, so the next row opens a new set
// reset (rst_n low, synchronous) empties the basis, zeroes the rank and drops out_ch.valid
module gf2_rank_xor_basis #(
  parameter int unsigned ROW_BITS = gxb_pkg::ROW_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gxb_in_if.sink           in_ch,
  gxb_out_if.source        out_ch
);
  import gxb_pkg::*;

  gxb_cmd_t cmd;
  gxb_sts_t sts;

  gxb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gxb_datapath #(
    .ROW_BITS (ROW_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_row_value     (in_ch.row_value),
    .in_last_of_set   (in_ch.last_of_set),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_independent  (out_ch.independent),
    .out_pivot_bit    (out_ch.pivot_bit),
    .out_running_rank (out_ch.running_rank),
    .out_set_done     (out_ch.set_done)
  );

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import gxb_pkg::*;

  localparam int ROW_BITS     = ROW_BITS_DEF;
  localparam int ITEM_TARGET  = 1450;
  localparam int DRAIN_CYCLES = ROW_BITS + 16;
  localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - ROW_BITS);

  typedef struct {
    logic [ROW_W-1:0] row;
    logic             last;
    logic             hold;
  } row_item_t;

  typedef struct {
    logic               independent;
    logic [PIVOT_W-1:0] pivot_bit;
    logic [RANK_W-1:0]  running_rank;
    logic               set_done;
  } rank_result_t;

  logic clk;
  logic rst_n;

  gxb_in_if  in_ch();
  gxb_out_if out_ch();

  gf2_rank_xor_basis #(.ROW_BITS(ROW_BITS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  row_item_t        rows_q[$];
  rank_result_t     rank_results_q[$];
  logic [ROW_W-1:0] basis_rows[ROW_W];
  logic [RANK_W-1:0] rank_count;
  int               rows_sent;
  int               errors;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_basis();
    for (int i = 0; i < ROW_W; i++) basis_rows[i] = '0;
    rank_count = '0;
  endfunction

  function automatic rank_result_t reduce_row(input logic [ROW_W-1:0] row, input logic last);
    rank_result_t     res;
    logic [ROW_W-1:0] x;
    x                = row & ROW_MASK;
    res.independent  = 1'b0;
    res.pivot_bit    = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (x == '0) break;
      if (x[b]) begin
        if (basis_rows[b] == '0) begin
          basis_rows[b] = x;
          if (rank_count < RANK_W'(64)) rank_count = rank_count + 1'b1;
          res.independent = 1'b1;
          res.pivot_bit   = PIVOT_W'(b);
          break;
        end
        x = x ^ basis_rows[b];
      end
    end
    res.running_rank = rank_count;
    res.set_done     = last;
    if (last) clear_basis();
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic int tx_idle_pct();
    if (rows_sent < ITEM_TARGET / 3) return 19;
    if (rows_sent < 2 * ITEM_TARGET / 3) return 83;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (rows_sent < ITEM_TARGET / 3) return 83;
    if (rows_sent < 2 * ITEM_TARGET / 3) return 19;
    return 0;
  endfunction

  function automatic void push_row(input logic [ROW_W-1:0] row, input logic last);
    row_item_t it;
    int        n;
    n       = rows_q.size();
    it.row  = row;
    it.last = last;
    it.hold = (n == 20) || (n == ITEM_TARGET / 3) || (n == 2 * ITEM_TARGET / 3);
    rows_q.insert(rows_q.size(), it);
  endfunction

  // one set of rows with random shape; the last row closes the set
  function automatic void add_random_set();
    logic [ROW_W-1:0] gens[$];
    logic [ROW_W-1:0] set_rows[$];
    logic [ROW_W-1:0] tri_rows[ROW_W];
    logic [ROW_W-1:0] r;
    logic [ROW_W-1:0] tmp;
    int               kind;
    int               n;
    int               k;
    int               j;
    int               sel;
    kind = $urandom_range(99);
    if (kind < 4) begin
      for (int i = 0; i < ROW_W; i++)
        tri_rows[i] = (64'd1 << i) | (rand_row() & ((64'd1 << i) - 64'd1));
      for (int i = ROW_W - 1; i > 0; i--) begin
        j           = $urandom_range(i);
        tmp         = tri_rows[i];
        tri_rows[i] = tri_rows[j];
        tri_rows[j] = tmp;
      end
      n = $urandom_range(6);
      for (int i = 0; i < ROW_W; i++) push_row(tri_rows[i], (n == 0) && (i == ROW_W - 1));
      for (int i = 0; i < n; i++) push_row(rand_row(), i == n - 1);
      return;
    end
    if (kind < 30) begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) push_row(rand_row(), i == n - 1);
    end else if (kind < 60) begin
      k = $urandom_range(8, 1);
      for (int i = 0; i < k; i++)
        gens.insert(gens.size(),
                    ($urandom_range(1)) ? rand_row() : (rand_row() & rand_row() & rand_row()));
      n = $urandom_range(20, 1);
      for (int i = 0; i < n; i++) begin
        r   = '0;
        sel = $urandom;
        for (int g = 0; g < k; g++) if (sel[g]) r = r ^ gens[g];
        push_row(r, i == n - 1);
      end
    end else if (kind < 80) begin
      n = $urandom_range(16, 1);
      for (int i = 0; i < n; i++) begin
        r = '0;
        k = $urandom_range(3, 1);
        for (int b = 0; b < k; b++)
          r = r | (64'd1 << ($urandom_range(1) ? $urandom_range(63) : $urandom_range(7)));
        push_row(r, i == n - 1);
      end
    end else begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(5);
        if (set_rows.size() == 0 && sel >= 1 && sel <= 2) sel = 4;
        case (sel)
          0: r = '0;
          1: r = set_rows[$urandom_range(set_rows.size() - 1)];
          2: r = set_rows[$urandom_range(set_rows.size() - 1)] ^
                 set_rows[$urandom_range(set_rows.size() - 1)];
          3: r = '1;
          default: r = rand_row();
        endcase
        set_rows.insert(set_rows.size(), r);
        push_row(r, i == n - 1);
      end
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rank_results_q.insert(rank_results_q.size(),
                              reduce_row(in_ch.row_value, in_ch.last_of_set));
        void'(rows_q.pop_front());
        rows_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rows_q.size() != 0 && $urandom_range(99) >= tx_idle_pct() &&
            !(rows_q[0].hold && rank_results_q.size() != 0)) begin
          in_ch.valid       <= 1'b1;
          in_ch.row_value   <= rows_q[0].row;
          in_ch.last_of_set <= rows_q[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    rank_result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rank_results_q.size() == 0) begin
          $error("result with no row pending");
          errors++;
        end else begin
          exp_res = rank_results_q.pop_front();
          if (out_ch.independent !== exp_res.independent) begin
            $error("independent: expected %0d, actual %0d",
                   exp_res.independent, out_ch.independent);
            errors++;
          end
          if (out_ch.pivot_bit !== exp_res.pivot_bit) begin
            $error("pivot_bit: expected %0d, actual %0d", exp_res.pivot_bit, out_ch.pivot_bit);
            errors++;
          end
          if (out_ch.running_rank !== exp_res.running_rank) begin
            $error("running_rank: expected %0d, actual %0d",
                   exp_res.running_rank, out_ch.running_rank);
            errors++;
          end
          if (out_ch.set_done !== exp_res.set_done) begin
            $error("set_done: expected %0d, actual %0d", exp_res.set_done, out_ch.set_done);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.row_value    = '0;
    in_ch.last_of_set  = 1'b0;
    out_ch.ready       = 1'b0;
    rows_sent          = 0;
    errors             = 0;
    clear_basis();

    // zero row, full row, repeat, lowest bit, partial reduction
    push_row(64'h0, 1'b0);
    push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_row(64'h0000_0000_0000_0001, 1'b0);
    push_row(64'h8000_0000_0000_0001, 1'b0);
    push_row(64'h0000_0000_0000_0001, 1'b1);
    // single-row sets
    push_row(64'h0, 1'b1);
    push_row(64'h8000_0000_0000_0000, 1'b1);
    push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // alternating patterns and their sum
    push_row(64'h5555_5555_5555_5555, 1'b0);
    push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_row(64'h0, 1'b0);
    push_row(64'h0000_0000_0000_0003, 1'b0);
    push_row(64'hAAAA_AAAA_AAAA_AAA8, 1'b1);
    while (rows_q.size() < ITEM_TARGET) add_random_set();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (rows_q.size() != 0 || rank_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rank_results_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
